>>> rtl/ufrb_pkg.sv
`timescale 1ns / 1ps
package ufrb_pkg;

  localparam int FIFO_DEPTH_DEF = 16;
  localparam int BYTE_W         = 8;

  typedef enum logic [1:0] {
    CMD_BUS_READ  = 2'd0,
    CMD_BUS_WRITE = 2'd1,
    CMD_LINE_RX   = 2'd2,
    CMD_LINE_TX   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OFF_RXDATA = 2'd0,
    OFF_TXDATA = 2'd1,
    OFF_STATUS = 2'd2,
    OFF_CTRL   = 2'd3
  } reg_off_t;

  localparam int CTRL_TX_CLR_BIT = 0;
  localparam int CTRL_RX_CLR_BIT = 1;
  localparam int CTRL_IRQ_EN_BIT = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RX_POP,
    OP_STATUS,
    OP_TX_PUSH,
    OP_CTRL,
    OP_RX_PUSH,
    OP_TX_POP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] data;
  } op_entry_t;

  typedef struct packed {
    logic              rx_dropped;
    logic [BYTE_W-1:0] tx_byte;
    logic              tx_valid;
    logic [BYTE_W-1:0] read_data;
  } result_t;

  typedef enum logic {
    BK_IDLE,
    BK_WAIT
  } bk_state_t;

endpackage

>>> rtl/uart_fifo_register_block_core.sv
`timescale 1ns / 1ps
// uart register block with receive and transmit byte fifos
// input channel: one transfer per bus access or line event; in_tuser carries
//   the command (bus read, bus write, line byte received, transmitter drain)
// output channel: exactly one result transfer per input transfer, in order;
//   out_tdata has the bus read data and drained tx byte, out_tuser the
//   tx valid and rx dropped flags
// a two-entry queue sits between the decode front end and the fifo back end
// path: a result passes through the queue and the output register; a pop from
//   a non-empty fifo also passes through the registered ram read
// throughput: one transfer per cycle while the receiver takes results, except a
//   pop from a non-empty fifo, which holds the back end on the fifo ram read port
// reset: both fifos empty, interrupt enable cleared, queue and output empty;
//   fifo storage is not cleared and needs no clearing pass
// receiver stall: the result stays in the output register; the back end stops,
//   the queue fills, then in_tready drops
module uart_fifo_register_block_core
  import ufrb_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // reg_offset[1:0], write_data[9:2], line_byte[17:10]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data[7:0], tx_byte[15:8]
  output logic [1:0]  out_tuser   // tx_valid[0], rx_dropped[1]
);

  logic      q_valid;
  logic      q_pop;
  op_entry_t q_entry;
  result_t   res;

  ufrb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cmd        (in_tuser),
    .reg_offset (in_tdata[1:0]),
    .write_data (in_tdata[9:2]),
    .line_byte  (in_tdata[17:10]),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  ufrb_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {res.tx_byte, res.read_data};
  assign out_tuser = {res.rx_dropped, res.tx_valid};

endmodule

>>> rtl/ufrb_ram.sv
`timescale 1ns / 1ps
module ufrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ufrb_front.sv
`timescale 1ns / 1ps
module ufrb_front
  import ufrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [1:0]  reg_offset,
  input  logic [7:0]  write_data,
  input  logic [7:0]  line_byte,
  output logic        q_valid,
  output op_entry_t   q_entry,
  input  logic        q_pop
);

  op_entry_t   q_mem_r [2];
  logic        q_wr_r, q_wr_nxt;
  logic        q_rd_r, q_rd_nxt;
  logic [1:0]  q_cnt_r, q_cnt_nxt;
  op_entry_t   cls;
  logic        push;

  // classify the transfer into one operation for the back end
  always_comb begin
    cls.op   = OP_NONE;
    cls.data = write_data;
    case (cmd_t'(cmd))
      CMD_BUS_READ: begin
        case (reg_off_t'(reg_offset))
          OFF_RXDATA: cls.op = OP_RX_POP;
          OFF_STATUS: cls.op = OP_STATUS;
          default:    cls.op = OP_NONE;
        endcase
      end
      CMD_BUS_WRITE: begin
        case (reg_off_t'(reg_offset))
          OFF_TXDATA: cls.op = OP_TX_PUSH;
          OFF_CTRL:   cls.op = OP_CTRL;
          default:    cls.op = OP_NONE;
        endcase
      end
      CMD_LINE_RX: begin
        cls.op   = OP_RX_PUSH;
        cls.data = line_byte;
      end
      CMD_LINE_TX: cls.op = OP_TX_POP;
      default:     cls.op = OP_NONE;
    endcase
  end

  assign in_ready = (q_cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (q_cnt_r != 2'd0);
  assign q_entry  = q_mem_r[q_rd_r];

  always_comb begin
    q_wr_nxt  = q_wr_r;
    q_rd_nxt  = q_rd_r;
    q_cnt_nxt = q_cnt_r;
    if (push) begin
      q_wr_nxt = ~q_wr_r;
    end
    if (q_pop) begin
      q_rd_nxt = ~q_rd_r;
    end
    case ({push, q_pop})
      2'b10:   q_cnt_nxt = q_cnt_r + 2'd1;
      2'b01:   q_cnt_nxt = q_cnt_r - 2'd1;
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= 1'b0;
      q_rd_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      q_wr_r  <= q_wr_nxt;
      q_rd_r  <= q_rd_nxt;
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[q_wr_r] <= cls;
    end
  end

endmodule

>>> rtl/ufrb_back.sv
`timescale 1ns / 1ps
module ufrb_back
  import ufrb_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_entry_t q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  bk_state_t     state_r, state_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_t       res_r, res_nxt;
  logic          pend_tx_r, pend_tx_nxt;
  logic [PW-1:0] rx_rd_r, rx_rd_nxt, tx_rd_r, tx_rd_nxt;
  logic [CW-1:0] rx_cnt_r, rx_cnt_nxt, tx_cnt_r, tx_cnt_nxt;
  logic          irq_en_r, irq_en_nxt;

  logic          rx_we, rx_re, tx_we, tx_re;
  logic [7:0]    rx_rdata, tx_rdata;
  logic [PW-1:0] rx_wa, tx_wa, rx_rd_inc, tx_rd_inc;
  logic [CW:0]   rx_sum, tx_sum;
  logic          rx_full, tx_full, out_free;
  logic [7:0]    status;

  ufrb_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wa),
    .wdata (q_entry.data),
    .re    (rx_re),
    .raddr (rx_rd_r),
    .rdata (rx_rdata)
  );

  ufrb_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wa),
    .wdata (q_entry.data),
    .re    (tx_re),
    .raddr (tx_rd_r),
    .rdata (tx_rdata)
  );

  // write address is read pointer plus count, wrapped at the depth
  assign rx_sum = (CW+1)'(rx_rd_r) + (CW+1)'(rx_cnt_r);
  assign tx_sum = (CW+1)'(tx_rd_r) + (CW+1)'(tx_cnt_r);
  assign rx_wa  = (rx_sum >= (CW+1)'(FIFO_DEPTH)) ? PW'(rx_sum - (CW+1)'(FIFO_DEPTH))
                                                  : PW'(rx_sum);
  assign tx_wa  = (tx_sum >= (CW+1)'(FIFO_DEPTH)) ? PW'(tx_sum - (CW+1)'(FIFO_DEPTH))
                                                  : PW'(tx_sum);
  assign rx_rd_inc = (rx_rd_r == PW'(FIFO_DEPTH - 1)) ? '0 : rx_rd_r + PW'(1);
  assign tx_rd_inc = (tx_rd_r == PW'(FIFO_DEPTH - 1)) ? '0 : tx_rd_r + PW'(1);
  assign rx_full   = (rx_cnt_r == CW'(FIFO_DEPTH));
  assign tx_full   = (tx_cnt_r == CW'(FIFO_DEPTH));
  assign status    = {3'b000, irq_en_r, tx_full, (tx_cnt_r == '0), rx_full,
                      (rx_cnt_r != '0)};
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    pend_tx_nxt   = pend_tx_r;
    rx_rd_nxt     = rx_rd_r;
    tx_rd_nxt     = tx_rd_r;
    rx_cnt_nxt    = rx_cnt_r;
    tx_cnt_nxt    = tx_cnt_r;
    irq_en_nxt    = irq_en_r;
    rx_we         = 1'b0;
    rx_re         = 1'b0;
    tx_we         = 1'b0;
    tx_re         = 1'b0;
    q_pop         = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop         = 1'b1;
          res_nxt       = '0;
          out_valid_nxt = 1'b1;
          case (q_entry.op)
            OP_RX_POP: begin
              if (rx_cnt_r != '0) begin
                rx_re         = 1'b1;
                rx_rd_nxt     = rx_rd_inc;
                rx_cnt_nxt    = rx_cnt_r - CW'(1);
                pend_tx_nxt   = 1'b0;
                out_valid_nxt = 1'b0;
                state_nxt     = BK_WAIT;
              end
            end
            OP_TX_POP: begin
              if (tx_cnt_r != '0) begin
                tx_re         = 1'b1;
                tx_rd_nxt     = tx_rd_inc;
                tx_cnt_nxt    = tx_cnt_r - CW'(1);
                pend_tx_nxt   = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = BK_WAIT;
              end
            end
            OP_STATUS: res_nxt.read_data = status;
            OP_TX_PUSH: begin
              if (!tx_full) begin
                tx_we      = 1'b1;
                tx_cnt_nxt = tx_cnt_r + CW'(1);
              end
            end
            OP_RX_PUSH: begin
              if (!rx_full) begin
                rx_we      = 1'b1;
                rx_cnt_nxt = rx_cnt_r + CW'(1);
              end else begin
                res_nxt.rx_dropped = 1'b1;
              end
            end
            OP_CTRL: begin
              if (q_entry.data[CTRL_TX_CLR_BIT]) begin
                tx_rd_nxt  = '0;
                tx_cnt_nxt = '0;
              end
              if (q_entry.data[CTRL_RX_CLR_BIT]) begin
                rx_rd_nxt  = '0;
                rx_cnt_nxt = '0;
              end
              irq_en_nxt = q_entry.data[CTRL_IRQ_EN_BIT];
            end
            default: res_nxt = '0;
          endcase
        end
      end
      BK_WAIT: begin
        out_valid_nxt = 1'b1;
        res_nxt       = '0;
        if (pend_tx_r) begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_byte  = tx_rdata;
        end else begin
          res_nxt.read_data = rx_rdata;
        end
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      rx_rd_r     <= '0;
      tx_rd_r     <= '0;
      rx_cnt_r    <= '0;
      tx_cnt_r    <= '0;
      irq_en_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rx_rd_r     <= rx_rd_nxt;
      tx_rd_r     <= tx_rd_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      irq_en_r    <= irq_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    pend_tx_r <= pend_tx_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_rx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt_r <= CW'(FIFO_DEPTH)) else $error("rx count past depth");
  a_tx_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt_r <= CW'(FIFO_DEPTH)) else $error("tx count past depth");
  a_wait_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_WAIT |-> !out_valid_r) else $error("pop data with output busy");
  a_wait_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_WAIT |=> out_valid_r && state_r == BK_IDLE)
    else $error("pop result not presented");
  a_no_pop_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_WAIT |-> !q_pop) else $error("queue popped while waiting on ram");

endmodule

>>> verif/uart_fifo_register_block_checker.sv
`timescale 1ns / 1ps
module uart_fifo_register_block_checker
  import ufrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          fail_count,
  output int          pending
);

  localparam int DEPTH = FIFO_DEPTH_DEF;

  logic [7:0] rx_mem [DEPTH];
  logic [7:0] tx_mem [DEPTH];
  int         rx_head;
  int         rx_level;
  int         tx_head;
  int         tx_level;
  logic       irq_en;
  int         mismatches;
  result_t    awaited_results [$];

  function automatic result_t apply_uart_access(cmd_t cmd, reg_off_t off, logic [7:0] wdata,
                                                logic [7:0] lbyte);
    result_t r;
    r = '0;
    case (cmd)
      CMD_BUS_READ: begin
        if (off == OFF_RXDATA && rx_level != 0) begin
          r.read_data = rx_mem[rx_head];
          rx_head = (rx_head + 1) % DEPTH;
          rx_level--;
        end else if (off == OFF_STATUS) begin
          r.read_data = {3'b000, irq_en, tx_level == DEPTH, tx_level == 0,
                         rx_level == DEPTH, rx_level != 0};
        end
      end
      CMD_BUS_WRITE: begin
        if (off == OFF_TXDATA && tx_level < DEPTH) begin
          tx_mem[(tx_head + tx_level) % DEPTH] = wdata;
          tx_level++;
        end else if (off == OFF_CTRL) begin
          if (wdata[CTRL_TX_CLR_BIT]) begin
            tx_head = 0;
            tx_level = 0;
          end
          if (wdata[CTRL_RX_CLR_BIT]) begin
            rx_head = 0;
            rx_level = 0;
          end
          irq_en = wdata[CTRL_IRQ_EN_BIT];
        end
      end
      CMD_LINE_RX: begin
        if (rx_level < DEPTH) begin
          rx_mem[(rx_head + rx_level) % DEPTH] = lbyte;
          rx_level++;
        end else begin
          r.rx_dropped = 1'b1;
        end
      end
      default: begin
        if (tx_level != 0) begin
          r.tx_valid = 1'b1;
          r.tx_byte = tx_mem[tx_head];
          tx_head = (tx_head + 1) % DEPTH;
          tx_level--;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (!rst_n) begin
      rx_head = 0;
      rx_level = 0;
      tx_head = 0;
      tx_level = 0;
      irq_en = 1'b0;
      mismatches = 0;
      awaited_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[7:0];
        got.tx_byte = out_tdata[15:8];
        got.tx_valid = out_tuser[0];
        got.rx_dropped = out_tuser[1];
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing outstanding: rd=%02h txv=%0b txb=%02h drop=%0b",
                     $realtime, got.read_data, got.tx_valid, got.tx_byte, got.rx_dropped);
        end else begin
          want = awaited_results.pop_front();
          if (got.read_data !== want.read_data || got.tx_valid !== want.tx_valid ||
              got.tx_byte !== want.tx_byte || got.rx_dropped !== want.rx_dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp rd=%02h txv=%0b txb=%02h drop=%0b, got rd=%02h txv=%0b txb=%02h drop=%0b",
                       $realtime, want.read_data, want.tx_valid, want.tx_byte, want.rx_dropped,
                       got.read_data, got.tx_valid, got.tx_byte, got.rx_dropped);
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(apply_uart_access(cmd_t'(in_tuser), reg_off_t'(in_tdata[1:0]),
                                                    in_tdata[9:2], in_tdata[17:10]));
      fail_count <= mismatches;
      pending <= awaited_results.size();
    end
  end

endmodule

>>> verif/uart_fifo_register_block_core_test.sv
`timescale 1ns / 1ps
module uart_fifo_register_block_core_test;
  import ufrb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 100;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  int          fail_count;
  int          pending;

  int          idle_pct;
  int          stall_pct;
  int          items_sent;
  int          cycles;
  int          hold_left;
  bit          hold_req;
  bit          hold_ack;

  uart_fifo_register_block_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  uart_fifo_register_block_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver side, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_op(cmd_t cmd, reg_off_t off, logic [7:0] wdata, logic [7:0] lbyte);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {6'b000000, lbyte, wdata, off};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  initial begin
    int target;
    int kind;
    int burst;
    logic [7:0] ctrl_mask;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    cycles = 0;
    hold_left = 0;
    hold_req = 1'b0;
    hold_ack = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    out_tready <= 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 47;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 47;
        end
        default: begin
          idle_pct = 23;
          stall_pct = 23;
        end
      endcase

      if (phase == 0) begin
        // empty fifos, unreadable registers, ignored writes
        send_op(CMD_BUS_READ, OFF_RXDATA, 8'hff, 8'hff);
        send_op(CMD_BUS_READ, OFF_STATUS, 8'h00, 8'h00);
        send_op(CMD_BUS_READ, OFF_TXDATA, 8'h00, 8'h00);
        send_op(CMD_BUS_READ, OFF_CTRL, 8'hff, 8'h00);
        send_op(CMD_LINE_TX, OFF_RXDATA, 8'hff, 8'hff);
        send_op(CMD_BUS_WRITE, OFF_RXDATA, 8'hff, 8'h00);
        send_op(CMD_BUS_WRITE, OFF_STATUS, 8'hff, 8'h00);
        send_op(CMD_BUS_WRITE, OFF_CTRL, 8'h10, 8'h00);
        send_op(CMD_BUS_READ, OFF_STATUS, 8'h00, 8'h00);
        // byte extremes through both fifos
        send_op(CMD_BUS_WRITE, OFF_TXDATA, 8'h00, 8'hff);
        send_op(CMD_BUS_WRITE, OFF_TXDATA, 8'hff, 8'h00);
        send_op(CMD_BUS_READ, OFF_STATUS, 8'h00, 8'h00);
        send_op(CMD_LINE_TX, OFF_CTRL, 8'h00, 8'h00);
        send_op(CMD_LINE_TX, OFF_STATUS, 8'h00, 8'h00);
        send_op(CMD_LINE_RX, OFF_CTRL, 8'h00, 8'hff);
        send_op(CMD_LINE_RX, OFF_TXDATA, 8'hff, 8'h00);
        send_op(CMD_BUS_READ, OFF_STATUS, 8'h00, 8'h00);
        send_op(CMD_BUS_READ, OFF_RXDATA, 8'h00, 8'h00);
        // clears with data still queued
        send_op(CMD_BUS_WRITE, OFF_TXDATA, 8'ha5, 8'h5a);
        send_op(CMD_BUS_WRITE, OFF_CTRL, 8'h03, 8'h00);
        send_op(CMD_BUS_READ, OFF_STATUS, 8'h00, 8'h00);
        send_op(CMD_LINE_TX, OFF_RXDATA, 8'h00, 8'h00);
        send_op(CMD_BUS_READ, OFF_RXDATA, 8'h00, 8'h00);
        send_op(CMD_BUS_WRITE, OFF_CTRL, 8'hff, 8'h00);
        send_op(CMD_BUS_READ, OFF_STATUS, 8'h00, 8'h00);
        hold_req <= ~hold_req;
      end

      target = items_sent + 220;
      while (items_sent < target) begin
        kind = $urandom_range(0, 9);
        burst = $urandom_range(1, 20);
        case (kind)
          0, 1: repeat (burst)
            send_op(CMD_LINE_RX, reg_off_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
          2, 3: repeat (burst)
            send_op(CMD_BUS_READ, ($urandom_range(0, 4) == 0) ? OFF_STATUS : OFF_RXDATA,
                    8'($urandom), 8'($urandom));
          4, 5: repeat (burst)
            send_op(CMD_BUS_WRITE, OFF_TXDATA, 8'($urandom), 8'($urandom));
          6: repeat (burst)
            send_op(CMD_LINE_TX, reg_off_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
          7: begin
            ctrl_mask = ($urandom_range(0, 3) == 0) ? 8'hff : 8'hfc;
            send_op(CMD_BUS_READ, OFF_STATUS, 8'($urandom), 8'($urandom));
            send_op(CMD_BUS_WRITE, OFF_CTRL, 8'($urandom) & ctrl_mask, 8'($urandom));
          end
          default: repeat (burst)
            send_op(cmd_t'($urandom_range(0, 3)), reg_off_t'($urandom_range(0, 3)),
                    8'($urandom), 8'($urandom));
        endcase
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
